FILE: rtl/core/vtks_pkg.sv
// Package for the versioned top-k L2 search block.
// Holds shared types, codes and a helper function; no dependencies.
package vtks_pkg;

   localparam int MAX_DIM_DEFAULT     = 128;
   localparam int MAX_RECORDS_DEFAULT = 256;
   localparam int MAX_TOPK_DEFAULT    = 16;
   localparam int RESULT_CAP          = 16;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [1:0] CMD_QUERY  = 2'd0;
   localparam logic [1:0] CMD_RECORD = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [1:0] CSR_RESULT_LIMIT  = 2'd0;
   localparam logic [1:0] CSR_VECTOR_LENGTH = 2'd1;
   localparam logic [1:0] CSR_READ_SEQUENCE = 2'd2;

   localparam logic [1:0] FLAG_DELETED   = 2'b01;
   localparam logic [1:0] FLAG_LENGTH_OK = 2'b10;

   typedef enum logic [1:0] {
      KIND_QUERY,
      KIND_RECORD,
      KIND_FINISH
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic [31:0]        node_key;
      logic [31:0]        version;
      logic               tombstone;
      logic signed [15:0] component;
      logic               end_of_vector;
   } item_type;

   typedef struct packed {
      logic [4:0]  result_limit;
      logic [7:0]  vector_length;
      logic [31:0] visible_seq;
   } cfg_type;

   typedef struct packed {
      logic [31:0] node;
      logic [31:0] version;
      logic [1:0]  flags;
      logic [47:0] distance;
   } entry_type;

   // Nearest first, lower node id wins a tie.
   function automatic logic entry_before(logic [47:0] da, logic [31:0] na,
                                         logic [47:0] db, logic [31:0] nb);
      logic r;
      if (da != db) begin
         r = (da < db);
      end else begin
         r = (na < nb);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/versioned_topk_l2_search.sv
// Top level of the versioned top-k squared L2 search block.
// Depends on vtks_pkg, vtks_front, vtks_back and vtks_ram.
//
// Usage:
//   The req_ channel carries one transaction per vector element. Command
//   query stores the element in the query vector; command record adds the
//   squared difference to the running distance and, on end_of_vector,
//   enters the record into the per-node version table; command finish
//   reports up to result_limit nodes (capped at KCAP) on the rsp_ channel,
//   nearest first, last one flagged, then empties the table. Unused commands
//   are dropped. The csr_ port writes result_limit, vector_length and the read
//   sequence with no wait; write it only while the block is idle.
// Flow:
//   A two-entry queue decouples the input from the back end. A query element
//   is stored directly; a record element goes through query RAM read, square
//   and accumulate. A record end scans the table one entry at a time through
//   the single table RAM read port. A finish scans the whole table once per
//   reported node, and once more unless result_limit is reached.
// Reset clears the queue, table fill, counters and output valid; the query
// vector is undefined until written. While rsp_ready is low the result is
// held, a report waits at its next result; the queue accepts until full.
module versioned_topk_l2_search #(
   parameter int MAX_DIM     = vtks_pkg::MAX_DIM_DEFAULT,
   parameter int MAX_RECORDS = vtks_pkg::MAX_RECORDS_DEFAULT,
   parameter int MAX_TOPK    = vtks_pkg::MAX_TOPK_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [31:0]        req_node_key,
   input  logic [31:0]        req_version,
   input  logic               req_tombstone,
   input  logic signed [15:0] req_component,
   input  logic               req_end_of_vector,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_found_node,
   output logic [47:0]        rsp_squared_distance,
   output logic [3:0]         rsp_rank,
   output logic               rsp_none_found,
   output logic               rsp_last_result,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_write_data
);
   import vtks_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // Decode configuration writes; an unknown index changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RESULT_LIMIT:  cfg_in.result_limit  = csr_write_data[4:0];
            CSR_VECTOR_LENGTH: cfg_in.vector_length = csr_write_data[7:0];
            CSR_READ_SEQUENCE: cfg_in.visible_seq   = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.result_limit  <= 5'd10;
         cfg_ff.vector_length <= 8'd128;
         cfg_ff.visible_seq   <= 32'hFFFF_FFFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Accept and classify transactions.
   vtks_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_node_key      (req_node_key),
      .req_version       (req_version),
      .req_tombstone     (req_tombstone),
      .req_component     (req_component),
      .req_end_of_vector (req_end_of_vector),
      .q_valid           (q_valid),
      .q_item            (q_item),
      .q_pop             (q_pop)
   );

   // Accumulate, update the version table and run the report.
   vtks_back #(
      .MAX_DIM     (MAX_DIM),
      .MAX_RECORDS (MAX_RECORDS),
      .MAX_TOPK    (MAX_TOPK)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .q_valid              (q_valid),
      .q_item               (q_item),
      .q_pop                (q_pop),
      .cfg                  (cfg_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_found_node       (rsp_found_node),
      .rsp_squared_distance (rsp_squared_distance),
      .rsp_rank             (rsp_rank),
      .rsp_none_found       (rsp_none_found),
      .rsp_last_result      (rsp_last_result)
   );
endmodule

FILE: rtl/core/vtks_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vtks_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/vtks_front.sv
// Front end: accepts request transactions, classifies the command and
// queues the item for the back end. Depends on vtks_pkg.
module vtks_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [31:0]        req_node_key,
   input  logic [31:0]        req_version,
   input  logic               req_tombstone,
   input  logic signed [15:0] req_component,
   input  logic               req_end_of_vector,
   output logic               q_valid,
   output vtks_pkg::item_type q_item,
   input  logic               q_pop
);
   import vtks_pkg::*;

   item_type   slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       known;
   item_type   incoming;

   always_comb begin
      known = 1'b1;
      incoming.node_key      = req_node_key;
      incoming.version       = req_version;
      incoming.tombstone     = req_tombstone;
      incoming.component     = req_component;
      incoming.end_of_vector = req_end_of_vector;
      case (req_command)
         CMD_QUERY:  incoming.kind = KIND_QUERY;
         CMD_RECORD: incoming.kind = KIND_RECORD;
         CMD_FINISH: incoming.kind = KIND_FINISH;
         default: begin
            // drop the unused command at the door
            incoming.kind = KIND_QUERY;
            known = 1'b0;
         end
      endcase
   end

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && known;
   assign q_valid   = (count_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("front queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty front queue");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("front queue count lost a push");
endmodule

FILE: rtl/core/vtks_back.sv
// Back end: distance accumulation, versioned table update and top-k report.
// Depends on vtks_pkg and vtks_ram.
module vtks_back #(
   parameter int MAX_DIM     = vtks_pkg::MAX_DIM_DEFAULT,
   parameter int MAX_RECORDS = vtks_pkg::MAX_RECORDS_DEFAULT,
   parameter int MAX_TOPK    = vtks_pkg::MAX_TOPK_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  vtks_pkg::item_type q_item,
   output logic               q_pop,
   input  vtks_pkg::cfg_type  cfg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [31:0]        rsp_found_node,
   output logic [47:0]        rsp_squared_distance,
   output logic [3:0]         rsp_rank,
   output logic               rsp_none_found,
   output logic               rsp_last_result
);
   import vtks_pkg::*;

   localparam int QAW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW   = $clog2(MAX_DIM + 2);
   localparam int LW   = (CW > 8) ? CW : 8;
   localparam int TAW  = $clog2(MAX_RECORDS);
   localparam int FW   = $clog2(MAX_RECORDS + 1);
   localparam int KCAP = (MAX_TOPK < RESULT_CAP) ? MAX_TOPK : RESULT_CAP;
   localparam int EW   = $bits(entry_type);

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_ACC, ST_CRD, ST_CCHK, ST_CAPP,
      ST_RSTART, ST_RRD, ST_RCHK, ST_REND, ST_FIN
   } state_type;

   state_type         state_ff, state_in;
   item_type          item_ff, item_in;
   logic              inrange_ff, inrange_in;
   logic [31:0]       sq_ff, sq_in;
   logic [47:0]       acc_ff, acc_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [1:0]        flags_ff, flags_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [FW-1:0]     idx_ff, idx_in;
   logic [4:0]        limit_ff, limit_in;
   logic [4:0]        rank_ff, rank_in;
   entry_type         best_ff, best_in;
   logic              have_best_ff, have_best_in;
   entry_type         pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [3:0]        pend_rank_ff, pend_rank_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_node_ff, rsp_node_in;
   logic [47:0]       rsp_dist_ff, rsp_dist_in;
   logic [3:0]        rsp_rank_ff, rsp_rank_in;
   logic              rsp_none_ff, rsp_none_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              q_wr_en;
   logic [15:0]       q_rd_data;
   logic              t_wr_en;
   logic [TAW-1:0]    t_wr_addr;
   entry_type         t_wr_data;
   logic [TAW-1:0]    t_rd_addr;
   logic [EW-1:0]     t_rd_raw;
   entry_type         t_entry;

   logic              out_free;
   logic signed [16:0] diff;
   logic [15:0]       mag;
   logic [48:0]       sum;
   logic [CW-1:0]     count_inc;
   logic              len_ok;
   logic              qualifies;
   logic [4:0]        limit_now;

   vtks_ram #(.WIDTH(16), .DEPTH(MAX_DIM), .ADDR_W(QAW)) u_query_ram (
      .clock   (clock),
      .wr_en   (q_wr_en),
      .wr_addr (count_ff[QAW-1:0]),
      .wr_data (q_item.component),
      .rd_addr (count_ff[QAW-1:0]),
      .rd_data (q_rd_data)
   );

   vtks_ram #(.WIDTH(EW), .DEPTH(MAX_RECORDS), .ADDR_W(TAW)) u_table_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (t_wr_data),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_raw)
   );

   assign t_entry   = entry_type'(t_rd_raw);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign count_inc = (count_ff <= CW'(MAX_DIM)) ? count_ff + CW'(1) : count_ff;
   assign limit_now = (cfg.result_limit > 5'(KCAP)) ? 5'(KCAP) : cfg.result_limit;

   always_comb begin
      diff = $signed({item_ff.component[15], item_ff.component}) -
             $signed(inrange_ff ? {q_rd_data[15], q_rd_data} : 17'sd0);
      mag  = diff[16] ? 16'(-diff) : diff[15:0];
      sum  = {1'b0, acc_ff} + 49'(sq_ff);
      len_ok = (cfg.vector_length != 8'd0) &&
               (LW'(cfg.vector_length) <= LW'(MAX_DIM)) &&
               (LW'(count_inc) == LW'(cfg.vector_length));
      qualifies = (t_entry.flags == FLAG_LENGTH_OK) &&
                  ((rank_ff == 5'd0) ||
                   entry_before(pend_ff.distance, pend_ff.node,
                                t_entry.distance, t_entry.node)) &&
                  (!have_best_ff ||
                   entry_before(t_entry.distance, t_entry.node,
                                best_ff.distance, best_ff.node));
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      inrange_in    = inrange_ff;
      sq_in         = sq_ff;
      acc_in        = acc_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      limit_in      = limit_ff;
      rank_in       = rank_ff;
      best_in       = best_ff;
      have_best_in  = have_best_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      pend_rank_in  = pend_rank_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_node_in   = rsp_node_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_none_in   = rsp_none_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      q_wr_en       = 1'b0;
      t_wr_en       = 1'b0;
      t_wr_addr     = idx_ff[TAW-1:0];
      t_wr_data     = '{node: item_ff.node_key, version: item_ff.version,
                        flags: flags_ff, distance: acc_ff};
      t_rd_addr     = idx_ff[TAW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               item_in = q_item;
               case (q_item.kind)
                  KIND_QUERY: begin
                     q_wr_en  = (count_ff < CW'(MAX_DIM));
                     count_in = count_inc;
                     if (q_item.end_of_vector) begin
                        count_in = '0;
                        acc_in   = '0;
                     end
                  end
                  KIND_RECORD: begin
                     // query read issued at the current count
                     inrange_in = (count_ff < CW'(MAX_DIM));
                     state_in   = ST_SQ;
                  end
                  KIND_FINISH: begin
                     limit_in      = limit_now;
                     rank_in       = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_RSTART;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SQ: begin
            sq_in    = 32'(mag) * 32'(mag);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = sum[48] ? '1 : sum[47:0];
            count_in = count_inc;
            flags_in = (item_ff.tombstone ? FLAG_DELETED : 2'b00) |
                       (len_ok ? FLAG_LENGTH_OK : 2'b00);
            idx_in   = '0;
            if (item_ff.end_of_vector) begin
               if (item_ff.version > cfg.visible_seq) begin
                  count_in = '0;
                  acc_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_CRD;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_CRD: begin
            state_in = (idx_ff == fill_ff) ? ST_CAPP : ST_CCHK;
         end
         ST_CCHK: begin
            if (t_entry.node == item_ff.node_key) begin
               // only a strictly newer version replaces the stored one
               t_wr_en  = (item_ff.version > t_entry.version);
               count_in = '0;
               acc_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + FW'(1);
               state_in = ST_CRD;
            end
         end
         ST_CAPP: begin
            t_wr_addr = fill_ff[TAW-1:0];
            if (fill_ff < FW'(MAX_RECORDS)) begin
               t_wr_en = 1'b1;
               fill_in = fill_ff + FW'(1);
            end
            count_in = '0;
            acc_in   = '0;
            state_in = ST_IDLE;
         end
         ST_RSTART: begin
            idx_in       = '0;
            have_best_in = 1'b0;
            state_in     = (rank_ff == limit_ff) ? ST_FIN : ST_RRD;
         end
         ST_RRD: begin
            state_in = (idx_ff == fill_ff) ? ST_REND : ST_RCHK;
         end
         ST_RCHK: begin
            if (qualifies) begin
               best_in      = t_entry;
               have_best_in = 1'b1;
            end
            idx_in   = idx_ff + FW'(1);
            state_in = ST_RRD;
         end
         ST_REND: begin
            if (!have_best_ff) begin
               state_in = ST_FIN;
            end else if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_node_in  = pend_ff.node;
                  rsp_dist_in  = pend_ff.distance;
                  rsp_rank_in  = pend_rank_ff;
                  rsp_none_in  = 1'b0;
                  rsp_last_in  = 1'b0;
               end
               pend_in       = best_ff;
               pend_valid_in = 1'b1;
               pend_rank_in  = rank_ff[3:0];
               rank_in       = rank_ff + 5'd1;
               state_in      = ST_RSTART;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_node_in   = pend_valid_ff ? pend_ff.node : 32'd0;
               rsp_dist_in   = pend_valid_ff ? pend_ff.distance : 48'd0;
               rsp_rank_in   = pend_valid_ff ? pend_rank_ff : 4'd0;
               rsp_none_in   = !pend_valid_ff;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               fill_in       = '0;
               count_in      = '0;
               acc_in        = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         acc_ff        <= '0;
         count_ff      <= '0;
         fill_ff       <= '0;
         have_best_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acc_ff        <= acc_in;
         count_ff      <= count_in;
         fill_ff       <= fill_in;
         have_best_ff  <= have_best_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff      <= item_in;
      inrange_ff   <= inrange_in;
      sq_ff        <= sq_in;
      flags_ff     <= flags_in;
      idx_ff       <= idx_in;
      limit_ff     <= limit_in;
      rank_ff      <= rank_in;
      best_ff      <= best_in;
      pend_ff      <= pend_in;
      pend_rank_ff <= pend_rank_in;
      rsp_node_ff  <= rsp_node_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_none_ff  <= rsp_none_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found_node       = rsp_node_ff;
   assign rsp_squared_distance = rsp_dist_ff;
   assign rsp_rank             = rsp_rank_ff;
   assign rsp_none_found       = rsp_none_ff;
   assign rsp_last_result      = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(MAX_RECORDS))
      else $error("table fill beyond capacity");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DIM + 1))
      else $error("element count beyond saturation");
   a_none_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_none_ff) |-> (rsp_last_ff && rsp_node_ff == 32'd0))
      else $error("empty report not a lone last result");
   a_finish_empties: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && out_free) |=> (fill_ff == '0 && state_ff == ST_IDLE))
      else $error("report end did not empty the table");
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RCHK || state_ff == ST_CCHK) |-> (idx_ff < fill_ff))
      else $error("table scan read past fill");
endmodule

FILE: sim/versioned_topk_l2_search_tb.sv
// Self-checking testbench for versioned_topk_l2_search: random and directed
// query/record/finish traffic with an inline top-k predictor and scoreboard.
// Depends on vtks_pkg and the RTL of the block only.
module versioned_topk_l2_search_tb;
   import vtks_pkg::*;

   localparam logic [1:0]  CMD_UNUSED  = 2'd3;
   localparam int          DIM         = 128;
   localparam int          QUERY_LOAD  = 8;
   localparam int          TABLE_SIZE  = 256;
   localparam int          TOPK        = 16;
   localparam logic [47:0] DIST_SAT    = 48'hFFFF_FFFF_FFFF;
   localparam int          CYCLE_LIMIT = 1500000;
   localparam int          SETTLE      = 200;

   typedef struct {
      logic [1:0]  cmd;
      logic [31:0] node;
      logic [31:0] ver;
      logic        tomb;
      logic [15:0] comp;
      logic        eov;
      bit          drain;
   } req_item_type;

   typedef struct {
      logic [31:0] node;
      logic [47:0] sq_distance;
      logic [3:0]  rank;
      logic        none;
      logic        last;
   } rank_entry_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command = '0;
   logic [31:0]        req_node_key = '0;
   logic [31:0]        req_version = '0;
   logic               req_tombstone = 1'b0;
   logic signed [15:0] req_component = '0;
   logic               req_end_of_vector = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [31:0]        rsp_found_node;
   logic [47:0]        rsp_squared_distance;
   logic [3:0]         rsp_rank;
   logic               rsp_none_found;
   logic               rsp_last_result;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_write_data = '0;

   versioned_topk_l2_search u_dut (.*);

   always #6 clock = ~clock;

   // Predictor state: registers, query, running sum and the version table.
   logic [4:0]         lim_reg = 5'd10;
   logic [7:0]         len_reg = 8'd128;
   logic [31:0]        seq_reg = 32'hFFFF_FFFF;
   logic signed [15:0] query_vec [DIM];
   logic [47:0]        run_sum = '0;
   int                 elem_cnt = 0;
   logic [31:0]        tbl_node [TABLE_SIZE];
   logic [31:0]        tbl_ver  [TABLE_SIZE];
   logic [1:0]         tbl_flags[TABLE_SIZE];
   logic [47:0]        tbl_dist [TABLE_SIZE];
   int                 tbl_fill = 0;

   req_item_type       pending_reqs[$];
   rank_entry_type     expected_ranks[$];

   int                 errors = 0;
   int                 cycles = 0;
   int                 random_items = 0;
   int                 reports = 0;
   int                 empty_reports = 0;
   int                 ranks_seen = 0;
   bit                 random_part = 0;
   bit                 req_taken = 0;
   int                 gap_left = 0;
   int                 burst_left = 0;
   int                 hold_left = 0;
   bit                 hold_req = 0;
   bit                 hold_ack = 0;

   // Enter one finished record into the version table.
   task automatic commit_version(logic [31:0] node, logic [31:0] ver, logic tomb);
      logic [1:0] flags;
      bit         len_ok;
      if (ver > seq_reg) return;
      len_ok = len_reg >= 1 && len_reg <= DIM && elem_cnt == len_reg;
      flags = (tomb ? FLAG_DELETED : 2'b00) | (len_ok ? FLAG_LENGTH_OK : 2'b00);
      for (int i = 0; i < tbl_fill; i++) begin
         if (tbl_node[i] == node) begin
            if (ver > tbl_ver[i]) begin
               tbl_ver[i] = ver;
               tbl_flags[i] = flags;
               tbl_dist[i] = run_sum;
            end
            return;
         end
      end
      if (tbl_fill >= TABLE_SIZE) return;
      tbl_node[tbl_fill] = node;
      tbl_ver[tbl_fill] = ver;
      tbl_flags[tbl_fill] = flags;
      tbl_dist[tbl_fill] = run_sum;
      tbl_fill++;
   endtask

   // Select the nearest qualifying nodes and queue them as expected ranks.
   task automatic predict_ranking();
      int             limit;
      int             found;
      bit             have;
      logic [47:0]    best_d, prev_d;
      logic [31:0]    best_n, prev_n;
      rank_entry_type e;
      limit = (lim_reg > TOPK) ? TOPK : lim_reg;
      found = 0;
      prev_d = '0;
      prev_n = '0;
      for (int r = 0; r < limit; r++) begin
         have = 0;
         best_d = '0;
         best_n = '0;
         for (int i = 0; i < tbl_fill; i++) begin
            if (tbl_flags[i] != FLAG_LENGTH_OK) continue;
            if (r > 0 && !entry_before(prev_d, prev_n, tbl_dist[i], tbl_node[i])) continue;
            if (!have || entry_before(tbl_dist[i], tbl_node[i], best_d, best_n)) begin
               have = 1;
               best_d = tbl_dist[i];
               best_n = tbl_node[i];
            end
         end
         if (!have) break;
         e = '{best_n, best_d, 4'(r), 1'b0, 1'b0};
         expected_ranks.insert(expected_ranks.size(), e);
         found++;
         prev_d = best_d;
         prev_n = best_n;
      end
      if (found == 0) begin
         e = '{32'd0, 48'd0, 4'd0, 1'b1, 1'b1};
         expected_ranks.insert(expected_ranks.size(), e);
         empty_reports++;
      end else begin
         expected_ranks[$].last = 1'b1;
      end
      reports++;
      tbl_fill = 0;
      run_sum = '0;
      elem_cnt = 0;
   endtask

   task automatic predict_item(req_item_type it);
      logic signed [15:0] q;
      longint             diff;
      longint             sum;
      case (it.cmd)
         CMD_QUERY: begin
            if (elem_cnt < DIM) query_vec[elem_cnt] = it.comp;
            if (elem_cnt <= DIM) elem_cnt++;
            if (it.eov) begin
               elem_cnt = 0;
               run_sum = '0;
            end
         end
         CMD_RECORD: begin
            q = (elem_cnt < DIM) ? query_vec[elem_cnt] : 16'sd0;
            diff = longint'($signed(it.comp)) - longint'(q);
            sum = longint'(run_sum) + diff * diff;
            run_sum = (sum > longint'(DIST_SAT)) ? DIST_SAT : sum[47:0];
            if (elem_cnt <= DIM) elem_cnt++;
            if (it.eov) begin
               commit_version(it.node, it.ver, it.tomb);
               elem_cnt = 0;
               run_sum = '0;
            end
         end
         CMD_FINISH: predict_ranking();
         default: ;
      endcase
   endtask

   // Sample both channels and the register port at the rising edge.
   always @(posedge clock) begin
      req_item_type   it;
      rank_entry_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_RESULT_LIMIT:  lim_reg = csr_write_data[4:0];
               CSR_VECTOR_LENGTH: len_reg = csr_write_data[7:0];
               CSR_READ_SEQUENCE: seq_reg = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            it = '{req_command, req_node_key, req_version, req_tombstone,
                   req_component, req_end_of_vector, 1'b0};
            predict_item(it);
            req_taken = 1;
         end
         if (rsp_valid && rsp_ready) begin
            ranks_seen++;
            if (expected_ranks.size() == 0) begin
               $error("result with no expectation: node %0h", rsp_found_node);
               errors++;
            end else begin
               e = expected_ranks.pop_front();
               if (rsp_found_node !== e.node) begin
                  $error("found_node exp %0h got %0h", e.node, rsp_found_node);
                  errors++;
               end
               if (rsp_squared_distance !== e.sq_distance) begin
                  $error("squared_distance exp %0h got %0h", e.sq_distance,
                         rsp_squared_distance);
                  errors++;
               end
               if (rsp_rank !== e.rank) begin
                  $error("rank exp %0d got %0d", e.rank, rsp_rank);
                  errors++;
               end
               if (rsp_none_found !== e.none) begin
                  $error("none_found exp %0b got %0b", e.none, rsp_none_found);
                  errors++;
               end
               if (rsp_last_result !== e.last) begin
                  $error("last_result exp %0b got %0b", e.last, rsp_last_result);
                  errors++;
               end
            end
         end
      end
   end

   // Drive the request channel in bursts; hold the payload until accepted.
   always @(negedge clock) begin
      req_item_type it;
      logic         next_valid;
      next_valid = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (pending_reqs.size() > 0 &&
                      !(pending_reqs[0].drain && expected_ranks.size() > 0)) begin
            it = pending_reqs.pop_front();
            req_command <= it.cmd;
            req_node_key <= it.node;
            req_version <= it.ver;
            req_tombstone <= it.tomb;
            req_component <= it.comp;
            req_end_of_vector <= it.eov;
            next_valid = 1'b1;
            req_taken = 0;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver: stall pattern that rotates through always ready, mostly ready and
   // mostly stalled, plus one long hold-off on request.
   always @(negedge clock) begin
      logic rdy;
      case ((cycles / 400) % 3)
         0: rdy = 1'b1;
         1: rdy = ($urandom_range(0, 3) != 0);
         default: rdy = ($urandom_range(0, 3) == 0);
      endcase
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = 500;
         rdy = 1'b0;
      end
      rsp_ready <= rdy;
   end

   function automatic logic [15:0] pick_component();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_req(logic [1:0] cmd, logic [31:0] node, logic [31:0] ver,
                            logic tomb, logic [15:0] comp, logic eov, bit drain = 0);
      req_item_type it;
      it = '{cmd, node, ver, tomb, comp, eov, drain};
      pending_reqs.insert(pending_reqs.size(), it);
      if (random_part) random_items++;
   endtask

   task automatic push_record(logic [31:0] node, logic [31:0] ver, logic tomb, int len);
      for (int i = 0; i < len; i++)
         queue_req(CMD_RECORD, node, ver, tomb, pick_component(), i == len - 1);
   endtask

   task automatic push_finish(bit drain = 0);
      queue_req(CMD_FINISH, 32'($urandom), 32'($urandom), 1'($urandom), 16'($urandom), 1'b0,
                drain);
   endtask

   // Wait until the block is idle, then let it settle.
   task automatic wait_idle();
      while (pending_reqs.size() > 0 || req_valid || expected_ranks.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(logic [4:0] lim, logic [7:0] len, logic [31:0] seq);
      wait_idle();
      write_reg(CSR_RESULT_LIMIT, 32'(lim));
      write_reg(CSR_VECTOR_LENGTH, 32'(len));
      write_reg(CSR_READ_SEQUENCE, seq);
   endtask

   initial begin
      int          len, nrec, node_base;
      logic [31:0] seq;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Load the leading query entries; no record is longer than this.
      for (int i = 0; i < QUERY_LOAD; i++)
         queue_req(CMD_QUERY, '0, '0, 1'b0, pick_component(), i == QUERY_LOAD - 1);

      // Directed: extremes, versions, tombstones, lengths and odd commands.
      set_config(5'd16, 8'd3, 32'd1000);
      push_finish();                                      // empty table
      push_record(32'h0000_0000, 32'd0, 1'b0, 3);
      push_record(32'hFFFF_FFFF, 32'd1000, 1'b0, 3);
      push_record(32'h0000_0005, 32'hFFFF_FFFF, 1'b0, 3); // invisible version
      push_record(32'h0000_0000, 32'd0, 1'b0, 3);         // equal version kept
      push_record(32'h0000_0007, 32'd10, 1'b0, 2);        // too short
      push_record(32'h0000_0009, 32'd10, 1'b0, 3);
      push_record(32'h0000_0009, 32'd11, 1'b1, 3);        // newer tombstone hides it
      queue_req(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1);
      queue_req(CMD_RECORD, 32'd3, 32'd1, 1'b0, 16'h7FFF, 1'b0); // cut by finish
      push_finish();

      // Every register at its extremes; mixed query and record counter.
      set_config(5'd0, 8'd1, 32'd0);
      push_record(32'd1, 32'd0, 1'b0, 1);
      push_finish();
      set_config(5'd31, 8'd0, 32'hFFFF_FFFF);
      push_record(32'd1, 32'd4, 1'b0, 1);
      push_finish();
      set_config(5'd1, 8'd255, 32'hFFFF_FFFF);
      push_record(32'd2, 32'd4, 1'b0, 2);
      push_finish();
      set_config(5'd16, 8'd2, 32'hFFFF_FFFF);
      queue_req(CMD_QUERY, '0, '0, 1'b0, pick_component(), 1'b0);
      push_record(32'd8, 32'd1, 1'b0, 1);                 // shares the counter
      push_record(32'd9, 32'd1, 1'b0, 2);
      push_finish();

      random_part = 1;
      for (int ph = 0; random_items < 125; ph++) begin
         len = $urandom_range(1, 6);
         seq = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : 32'($urandom);
         set_config(5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                 : $urandom_range(1, 16)),
                    8'(len), seq);
         if (ph == 1) hold_req = ~hold_req;            // long receiver hold-off
         nrec = $urandom_range(4, 14);
         node_base = $urandom_range(0, 3) == 0 ? 0 : $urandom;
         for (int r = 0; r < nrec; r++) begin
            case ($urandom_range(0, 11))
               0: queue_req(CMD_UNUSED, 32'($urandom), 32'($urandom), 1'($urandom),
                            16'($urandom), 1'($urandom));
               1: push_record(32'($urandom), 32'($urandom), 1'($urandom),
                              $urandom_range(1, len + 1));
               2: begin
                  push_record(32'(node_base + $urandom_range(0, 5)), seq, 1'b0, len - 1);
                  push_finish();
               end
               default: push_record(32'(node_base + $urandom_range(0, 5)),
                                    seq - 32'($urandom_range(0, 8)) + 32'($urandom_range(0, 2)),
                                    1'($urandom_range(0, 5) == 0),
                                    ($urandom_range(0, 5) == 0) ? len + 1 : len);
            endcase
         end
         push_finish(ph % 3 == 1);                     // sometimes wait for drain first
      end

      wait_idle();
      $display("Covered %0d random items, %0d reports (%0d empty), %0d ranked results.",
               random_items, reports, empty_reports, ranks_seen);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
